>>> design/ebr_pkg.sv
// Shared types and constants for the embedding bag reduction block.
// No dependencies; imported by ebr_div and embedding_bag_reduce.
`default_nettype none
package ebr_pkg;

  localparam int ROWS      = 1024;
  localparam int FEATURES  = 16;
  localparam int ROW_W     = 10;
  localparam int FEAT_W    = $clog2(FEATURES);
  localparam int TBL_DEPTH = ROWS * FEATURES;
  localparam int TBL_AW    = $clog2(TBL_DEPTH);
  localparam int ACC_W     = 40;
  localparam int WORD_W    = 16;
  localparam int CNT_W     = 16;
  localparam int QUO_W     = ACC_W - 8;
  localparam int CFG_W     = 2;

  typedef enum logic [1:0] {
    CMD_LOAD  = 2'd0,
    CMD_ADD   = 2'd1,
    CMD_CLOSE = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    RED_SUM  = 2'd0,
    RED_MEAN = 2'd1,
    RED_MAX  = 2'd2,
    RED_RSV  = 2'd3
  } mode_t;

  typedef enum logic {
    REG_MODE = 1'b0,
    REG_USW  = 1'b1
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADD,
    ST_DRAIN,
    ST_DIV_START,
    ST_DIV_WAIT
  } state_t;

endpackage
`default_nettype wire

>>> design/ebr_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module ebr_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16384
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

>>> design/ebr_div.sv
// Restoring divider, one quotient bit per cycle, for the mean reduction.
// Depends on ebr_pkg for widths.
`default_nettype none
module ebr_div (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      start,
  input  wire logic [ebr_pkg::QUO_W-1:0] dividend,
  input  wire logic [ebr_pkg::CNT_W-1:0] divisor,
  output logic                           busy,
  output logic      [ebr_pkg::QUO_W-1:0] quotient
);
  import ebr_pkg::*;

  logic [CNT_W-1:0]         rem;
  logic [CNT_W-1:0]         dsr;
  logic [$clog2(QUO_W)-1:0] step;
  logic [CNT_W:0]           shifted;

  assign shifted = {rem, quotient[QUO_W-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= '0;
    end else if (start) begin
      busy     <= 1'b1;
      step     <= '0;
      rem      <= '0;
      dsr      <= divisor;
      quotient <= dividend;
    end else if (busy) begin
      if (shifted >= {1'b0, dsr}) begin
        rem      <= CNT_W'(shifted - {1'b0, dsr});
        quotient <= {quotient[QUO_W-2:0], 1'b1};
      end else begin
        rem      <= shifted[CNT_W-1:0];
        quotient <= {quotient[QUO_W-2:0], 1'b0};
      end
      step <= step + 1'b1;
      if (step == ($clog2(QUO_W))'(QUO_W - 1)) begin
        busy <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

>>> design/embedding_bag_reduce.sv
// Top level of the embedding bag reduction block: table, sequencer, accumulators.
// Depends on ebr_pkg, ebr_ram and ebr_div.
//
//   channel   handshake                   payload
//   in        in_valid / in_ready         cmd, row_index, column, table_word, sample_weight
//   out       out_valid / out_ready       bag_number, feature_index, value, max_row,
//                                         bag_count, last
//   cfg       cfg_we (no wait)            cfg_index, cfg_data
//
// For an add item one table read is issued per feature, followed by a registered
// multiply stage and a saturating accumulate stage. A close item runs the
// bit-serial divider once per feature, in every mode; its quotient gives the
// result in sum and mean modes. Reset is synchronous and clears the accumulators,
// maxima, counts and configuration; the table holds whatever was last written.
// A stalled output holds the sequencer until the result register frees up; the
// final result of a bag does not block new items.
`default_nettype none
module embedding_bag_reduce (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [1:0]                     cmd,
  input  wire logic [ebr_pkg::ROW_W-1:0]      row_index,
  input  wire logic [3:0]                     column,
  input  wire logic signed [15:0]             table_word,
  input  wire logic signed [15:0]             sample_weight,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic [15:0]                         bag_number,
  output logic [3:0]                          feature_index,
  output logic signed [15:0]                  value,
  output logic signed [10:0]                  max_row,
  output logic [15:0]                         bag_count,
  output logic                                last,
  input  wire logic                           cfg_we,
  input  wire logic                           cfg_index,
  input  wire logic [ebr_pkg::CFG_W-1:0]      cfg_data
);
  import ebr_pkg::*;

  state_t state, state_next;

  // Configuration registers.
  mode_t mode;
  logic  use_sample_weights;

  // Bag state.
  logic signed [ACC_W-1:0]  acc     [FEATURES];
  logic signed [WORD_W-1:0] fmax    [FEATURES];
  logic signed [10:0]       fmaxrow [FEATURES];
  logic [CNT_W-1:0]         rows_in_bag;
  logic [15:0]              bag_counter;

  // Latched add item.
  logic [ROW_W-1:0]         add_row;
  logic signed [WORD_W-1:0] add_weight;
  logic                     add_first;

  // Feature counter shared by add issue and close emission.
  logic [FEAT_W-1:0] fcnt;
  logic              fcnt_clr;
  logic              fcnt_inc;
  logic              fcnt_last;

  // Add pipeline.
  logic                     v1, v2;
  logic [FEAT_W-1:0]        f1, f2;
  logic signed [31:0]       term;
  logic signed [WORD_W-1:0] rd_data;
  logic [TBL_AW-1:0]        raddr;
  logic                     issue;

  // Divider.
  logic               div_start;
  logic               div_busy;
  logic [QUO_W-1:0]   div_q;
  logic [ACC_W-1:0]   acc_mag;
  logic [CNT_W-1:0]   div_dsr;

  logic in_acc;
  logic load_out;
  logic bag_clear;
  logic rows_inc;
  logic load_we;

  assign in_acc    = in_valid && in_ready;
  assign in_ready  = (state == ST_IDLE);
  assign load_we   = in_acc && (cmd_t'(cmd) == CMD_LOAD);
  assign fcnt_last = (fcnt == FEAT_W'(FEATURES - 1));
  assign raddr     = {add_row, fcnt};

  ebr_ram #(.WIDTH(WORD_W), .DEPTH(TBL_DEPTH)) u_table (
    .clk   (clk),
    .we    (load_we),
    .waddr ({row_index, column[FEAT_W-1:0]}),
    .wdata (table_word),
    .raddr (raddr),
    .rdata (rd_data)
  );

  // The divider receives the magnitude of the sum already scaled down by 256,
  // so floor(floor(|acc| / 256) / count) equals the truncated mean.
  assign acc_mag = acc[fcnt][ACC_W-1] ? ACC_W'(-acc[fcnt]) : ACC_W'(acc[fcnt]);
  assign div_dsr = (mode == RED_MEAN && rows_in_bag != '0) ? rows_in_bag : CNT_W'(1);

  ebr_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (acc_mag[ACC_W-1:8]),
    .divisor  (div_dsr),
    .busy     (div_busy),
    .quotient (div_q)
  );

  // Sequencer.
  always_comb begin
    state_next = state;
    fcnt_clr   = 1'b0;
    fcnt_inc   = 1'b0;
    issue      = 1'b0;
    div_start  = 1'b0;
    load_out   = 1'b0;
    bag_clear  = 1'b0;
    rows_inc   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        fcnt_clr = 1'b1;
        if (in_acc) begin
          priority if (cmd_t'(cmd) == CMD_ADD) begin
            state_next = ST_ADD;
          end else if (cmd_t'(cmd) == CMD_CLOSE) begin
            state_next = ST_DIV_START;
          end else begin
            state_next = ST_IDLE;
          end
        end
      end
      ST_ADD: begin
        issue    = 1'b1;
        fcnt_inc = 1'b1;
        if (fcnt_last) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!v1 && !v2) begin
          rows_inc   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      ST_DIV_START: begin
        div_start  = 1'b1;
        state_next = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (!div_busy && (!out_valid || out_ready)) begin
          load_out = 1'b1;
          if (fcnt_last) begin
            bag_clear  = 1'b1;
            state_next = ST_IDLE;
          end else begin
            fcnt_inc   = 1'b1;
            state_next = ST_DIV_START;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fcnt <= '0;
    end else if (fcnt_clr) begin
      fcnt <= '0;
    end else if (fcnt_inc) begin
      fcnt <= fcnt + 1'b1;
    end
  end

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      mode               <= RED_SUM;
      use_sample_weights <= 1'b0;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_MODE: mode               <= mode_t'(cfg_data);
        REG_USW:  use_sample_weights <= cfg_data[0];
        default:  ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      add_row    <= row_index;
      add_weight <= sample_weight;
      add_first  <= (rows_in_bag == '0);
    end
  end

  // Pipeline valids: stage 1 sees table data, stage 2 accumulates.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= issue;
      v2 <= v1;
    end
  end

  // The product of two Q8.8 words always fits in 32 signed bits.
  always_ff @(posedge clk) begin
    f1 <= fcnt;
    f2 <= f1;
    if (v1) begin
      term <= use_sample_weights ? 32'(rd_data) * 32'(add_weight)
                                 : {{8{rd_data[WORD_W-1]}}, rd_data, 8'b0};
    end
  end

  // Per-feature bag state, cleared together at reset and at bag close.
  always_ff @(posedge clk) begin
    logic signed [ACC_W:0] sum;
    sum = {acc[f2][ACC_W-1], acc[f2]} + {{(ACC_W-31){term[31]}}, term};
    if (rst || bag_clear) begin
      for (int i = 0; i < FEATURES; i++) begin
        acc[i]     <= '0;
        fmax[i]    <= '0;
        fmaxrow[i] <= '1;
      end
    end else begin
      if (v1 && (add_first || rd_data > fmax[f1])) begin
        fmax[f1]    <= rd_data;
        fmaxrow[f1] <= {1'b0, add_row};
      end
      if (v2) begin
        if (sum[ACC_W] != sum[ACC_W-1]) begin
          acc[f2] <= sum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
        end else begin
          acc[f2] <= sum[ACC_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_in_bag <= '0;
      bag_counter <= '0;
    end else if (bag_clear) begin
      rows_in_bag <= '0;
      bag_counter <= bag_counter + 1'b1;
    end else if (rows_inc && rows_in_bag != '1) begin
      rows_in_bag <= rows_in_bag + 1'b1;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      bag_number    <= bag_counter;
      feature_index <= 4'(fcnt);
      last          <= fcnt_last;
      bag_count     <= (mode == RED_MEAN) ? rows_in_bag : '0;
      if (mode == RED_MAX) begin
        value   <= fmax[fcnt];
        max_row <= fmaxrow[fcnt];
      end else begin
        max_row <= '1;
        // Saturate the signed quotient to Q8.8.
        if (acc[fcnt][ACC_W-1]) begin
          value <= (div_q > QUO_W'(32768)) ? 16'sh8000 : 16'(-div_q);
        end else begin
          value <= (div_q > QUO_W'(32767)) ? 16'sh7fff : 16'(div_q);
        end
      end
    end
  end

  a_count_monotonic: assert property (@(posedge clk) disable iff (rst)
    !bag_clear |=> rows_in_bag >= $past(rows_in_bag))
    else $error("row count dropped outside a bag close");

  a_pipe_in_add: assert property (@(posedge clk) disable iff (rst)
    (v1 || v2) |-> (state == ST_ADD || state == ST_DRAIN))
    else $error("add pipeline active outside an add");

  a_div_idle_start: assert property (@(posedge clk) disable iff (rst)
    div_start |-> !div_busy)
    else $error("divider started while busy");

  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    bag_clear |=> rows_in_bag == '0 && state == ST_IDLE)
    else $error("bag close left rows behind");

endmodule
`default_nettype wire
